// File: src/assert_macros.svh
// Assertion macros used by the script sequencer issue stage.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property checked on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/i2c_css_pkg.sv
// Package for the I2C command script sequencer: sizes, codes and bundles.
// Used by every module of the block except i2c_css_ram; depends on nothing.
package i2c_css_pkg;

  localparam int SCRIPT_DEPTH = 64;
  localparam int PTR_W        = $clog2(SCRIPT_DEPTH);
  localparam int LINE_W       = 6;
  localparam int POS_W        = 6;
  localparam int POS_COUNT    = 1 << POS_W;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [LINE_W-1:0] line_num_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_SETPOS = 3'd1,
    MODE_RUN    = 3'd2,
    MODE_STEP   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_RESTART = 3'd1,
    OP_STOP    = 3'd2,
    OP_SEND    = 3'd3,
    OP_RECV    = 3'd4,
    OP_ACK     = 3'd5,
    OP_NACK    = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_RECV    = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_NACK    = 3'd6,
    ACT_STOP    = 3'd7
  } action_t;

  // One stored script line
  typedef struct packed {
    logic [2:0] cmd;
    byte_t      data;
    byte_t      tag;
  } line_t;

  // Item held between the accept register and the issue stage
  typedef struct packed {
    logic [2:0] mode;
    line_num_t  line_number;
    byte_t      rx_byte;
  } stage_t;

  // Result beat
  typedef struct packed {
    action_t   action;
    byte_t     tx_byte;
    logic      store_valid;
    byte_t     store_tag;
    byte_t     store_byte;
    line_num_t line_number;
    logic      running;
    logic      complete;
  } result_t;

endpackage

// File: src/i2c_css_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module i2c_css_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/i2c_css_front.sv
// Accept stage: write and run pointers, script RAM, and the item register.
// Depends on i2c_css_pkg and i2c_css_ram.
module i2c_css_front
  import i2c_css_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       mode,
  input  logic [2:0]       command,
  input  logic [7:0]       send_data,
  input  logic [7:0]       dest_tag,
  input  logic [POS_W-1:0] position,
  input  logic [7:0]       rx_byte,
  input  logic             s1_advance,
  output logic             s1_valid,
  output stage_t           s1,
  output line_t            s1_line
);

  logic  accept;
  logic  is_write;
  logic  is_run;
  ptr_t  wr_ptr, wr_ptr_next;
  ptr_t  rd_ptr, rd_ptr_next;
  ptr_t  wr_inc, rd_inc;
  ptr_t  raddr;
  line_t wline;
  ptr_t  pos_tbl [POS_COUNT];

  // Position to pointer, wrapped by the script depth (constant table)
  for (genvar g = 0; g < POS_COUNT; g++) begin : g_pos
    localparam ptr_t PosWrapped = ptr_t'(g % SCRIPT_DEPTH);
    assign pos_tbl[g] = PosWrapped;
  end

  assign in_ready = !s1_valid || s1_advance;
  assign accept   = in_valid && in_ready;
  assign is_write = (mode == MODE_WRITE);
  assign is_run   = (mode == MODE_RUN);

  assign wr_inc = (wr_ptr == ptr_t'(SCRIPT_DEPTH - 1)) ? '0 : wr_ptr + ptr_t'(1);
  assign rd_inc = (rd_ptr == ptr_t'(SCRIPT_DEPTH - 1)) ? '0 : rd_ptr + ptr_t'(1);

  // Pointer updates; the read pointer runs ahead on every step since an
  // idle run pointer is never used before the next run resets it.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (accept) begin
      case (mode)
        MODE_WRITE:  wr_ptr_next = wr_inc;
        MODE_SETPOS: wr_ptr_next = pos_tbl[position];
        MODE_RUN:    rd_ptr_next = ptr_t'(1);
        MODE_STEP:   rd_ptr_next = rd_inc;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // Line as stored: unused fields are zeroed
  always_comb begin
    wline.cmd  = command;
    wline.data = (command == OP_SEND) ? send_data : '0;
    wline.tag  = (command == OP_ACK || command == OP_NACK) ? dest_tag : '0;
  end

  assign raddr = is_run ? '0 : rd_ptr;

  i2c_css_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (SCRIPT_DEPTH)
  ) u_script (
    .clk   (clk),
    .we    (accept && is_write),
    .waddr (wr_ptr),
    .wdata (wline),
    .re    (accept),
    .raddr (raddr),
    .rdata (s1_line)
  );

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.mode        <= mode;
      s1.line_number <= line_num_t'(wr_ptr);
      s1.rx_byte     <= rx_byte;
    end
  end

endmodule

// File: src/i2c_css_issue.sv
// Issue stage: decodes the fetched line, keeps run/complete flags, and
// holds the result register. Depends on i2c_css_pkg and assert_macros.svh.
`include "assert_macros.svh"
module i2c_css_issue
  import i2c_css_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s1_valid,
  input  stage_t  s1,
  input  line_t   s1_line,
  output logic    s1_advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  logic    run_active, run_active_next;
  logic    done_flag, done_flag_next;
  logic    issue;
  result_t res_next;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign issue = (s1.mode == MODE_RUN) || (s1.mode == MODE_STEP && run_active);

  // Flag updates and line decode
  always_comb begin
    run_active_next = run_active;
    done_flag_next  = done_flag;
    res_next        = '0;
    res_next.action = ACT_NONE;
    case (s1.mode)
      MODE_WRITE: res_next.line_number = s1.line_number;
      MODE_RUN: begin
        done_flag_next  = 1'b0;
        run_active_next = 1'b1;
      end
      MODE_CLEAR: done_flag_next = 1'b0;
      default: ;
    endcase
    if (issue) begin
      case (s1_line.cmd) inside
        OP_START:   res_next.action = ACT_START;
        OP_RESTART: res_next.action = ACT_RESTART;
        OP_SEND: begin
          res_next.action  = ACT_SEND;
          res_next.tx_byte = s1_line.data;
        end
        OP_RECV:    res_next.action = ACT_RECV;
        OP_ACK, OP_NACK: begin
          res_next.action      = (s1_line.cmd == OP_ACK) ? ACT_ACK : ACT_NACK;
          res_next.store_valid = 1'b1;
          res_next.store_tag   = s1_line.tag;
          res_next.store_byte  = s1.rx_byte;
        end
        // stop and the unused code end the run
        default: begin
          res_next.action = ACT_STOP;
          run_active_next = 1'b0;
          done_flag_next  = 1'b1;
        end
      endcase
    end
    res_next.running  = run_active_next;
    res_next.complete = done_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      done_flag  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_advance) begin
        run_active <= run_active_next;
        done_flag  <= done_flag_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res <= res_next;
    end
  end

  `ASSERT_PROP(a_run_done_excl, clk, rst, !(run_active && done_flag), "running and complete both set")
  `ASSERT_IMPL(a_store_ack, clk, rst, out_valid, res.store_valid == (res.action == ACT_ACK || res.action == ACT_NACK), "store_valid does not match ack/nack action")
  `ASSERT_IMPL(a_stop_flags, clk, rst, out_valid && res.action == ACT_STOP, res.complete && !res.running, "stop result without end of run")
  `ASSERT_IMPL(a_tx_send, clk, rst, out_valid && res.tx_byte != '0, res.action == ACT_SEND, "tx byte on a non-send result")
  `ASSERT_NEXT(a_flags_hold, clk, rst, !s1_advance, $stable(run_active) && $stable(done_flag), "flags changed without an item")

endmodule

// File: src/i2c_command_script_sequencer_unit.sv
// I2C command script sequencer, top level.
// A result passes the script RAM read and item register, both loaded on the accept
// edge, then the issue/result register; out_ready low holds it in the item register.
// Throughput: one item per cycle while out_ready is high; a held result stalls in_ready.
// Reset (rst, synchronous, active high) clears pointers, run and complete
// flags and both valid stages; script lines are undefined until written.
module i2c_command_script_sequencer_unit
  import i2c_css_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       mode,
  input  logic [2:0]       command,
  input  logic [7:0]       send_data,
  input  logic [7:0]       dest_tag,
  input  logic [POS_W-1:0] position,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       action,
  output logic [7:0]       tx_byte,
  output logic             store_valid,
  output logic [7:0]       store_tag,
  output logic [7:0]       store_byte,
  output logic [LINE_W-1:0] line_number,
  output logic             running,
  output logic             complete
);

  logic    s1_valid;
  logic    s1_advance;
  stage_t  s1;
  line_t   s1_line;
  result_t res;

  i2c_css_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .command    (command),
    .send_data  (send_data),
    .dest_tag   (dest_tag),
    .position   (position),
    .rx_byte    (rx_byte),
    .s1_advance (s1_advance),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_line    (s1_line)
  );

  i2c_css_issue u_issue (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_line    (s1_line),
    .s1_advance (s1_advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign action      = res.action;
  assign tx_byte     = res.tx_byte;
  assign store_valid = res.store_valid;
  assign store_tag   = res.store_tag;
  assign store_byte  = res.store_byte;
  assign line_number = res.line_number;
  assign running     = res.running;
  assign complete    = res.complete;

endmodule
